// ===== sv/plane_clip_and_scale_check_core_assert.svh =====
// Assertion macros for the plane clip and scale check block.
`ifndef PLANE_CLIP_AND_SCALE_CHECK_CORE_ASSERT_SVH
`define PLANE_CLIP_AND_SCALE_CHECK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PCSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PCSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PCSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PCSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/pcsc_pkg.sv =====
package pcsc_pkg;
   localparam int NumW = 29;
   localparam int ProdW = 43;
   localparam logic [28:0] RatioMax = 29'h1FFF_FFFF;
   localparam logic [28:0] DoubleRatio = 29'(1 << 15);
   localparam logic [12:0] ResetWidth = 13'd1920;
   localparam logic [12:0] ResetHeight = 13'd1080;

   localparam logic [1:0] StatOk = 2'd0;
   localparam logic [1:0] StatLayout = 2'd1;
   localparam logic [1:0] StatScale = 2'd2;

   localparam logic [1:0] LayLinear = 2'd0;
   localparam logic [1:0] LayTiled = 2'd1;

   localparam logic [2:0] RegWidth = 3'd0;
   localparam logic [2:0] RegHeight = 3'd1;
   localparam logic [2:0] RegScale = 3'd2;
   localparam logic [2:0] RegDouble = 3'd3;
   localparam logic [2:0] RegTile = 3'd4;

   typedef struct packed {
      logic [28:0] num;
      logic [12:0] rem;
      logic [12:0] den;
      logic [28:0] quo;
   } pcsc_lane_type;

   typedef struct packed {
      logic [15:0] sx;
      logic [15:0] sy;
      logic [12:0] aw;
      logic [12:0] ah;
      logic [12:0] dxo;
      logic [12:0] dyo;
      logic [13:0] ovx;
      logic [13:0] ovy;
      logic        negx;
      logic        negy;
      logic        lay_ok;
   } pcsc_pay_type;

   function automatic logic [12:0] visible(input logic signed [13:0] start,
                                           input logic [12:0] len,
                                           input logic [12:0] last);
      logic signed [14:0] fin;
      logic [12:0] room;
      logic [12:0] res;
      fin = 15'(start) + $signed({2'b00, len});
      room = last - start[12:0];
      if (start <= 14'sd0) begin
         if (fin > 15'sd0) begin
            res = (fin[12:0] < last) ? fin[12:0] : last;
         end else begin
            res = '0;
         end
      end else if ({1'b0, start[12:0]} <= {1'b0, last}) begin
         res = (room < len) ? room : len;
      end else begin
         res = '0;
      end
      return res;
   endfunction
endpackage

// ===== sv/pcsc_req_if.sv =====
interface pcsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] dst_x;
   logic signed [13:0] dst_y;
   logic [12:0]        dst_w;
   logic [12:0]        dst_h;
   logic [31:0]        src_x_q16;
   logic [31:0]        src_y_q16;
   logic [28:0]        src_w_q16;
   logic [28:0]        src_h_q16;
   logic [1:0]         fb_layout;
   modport source(output valid, dst_x, dst_y, dst_w, dst_h, src_x_q16, src_y_q16,
                  src_w_q16, src_h_q16, fb_layout, input ready);
   modport sink(input valid, dst_x, dst_y, dst_w, dst_h, src_x_q16, src_y_q16,
                src_w_q16, src_h_q16, fb_layout, output ready);
endinterface

// ===== sv/pcsc_rsp_if.sv =====
interface pcsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] out_src_x;
   logic [16:0] out_src_y;
   logic [25:0] out_src_w;
   logic [25:0] out_src_h;
   logic [12:0] out_dst_x;
   logic [12:0] out_dst_y;
   logic [12:0] out_dst_w;
   logic [12:0] out_dst_h;
   logic [28:0] h_ratio;
   logic [28:0] v_ratio;
   logic [1:0]  status;
   modport source(output valid, out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x,
                  out_dst_y, out_dst_w, out_dst_h, h_ratio, v_ratio, status, input ready);
   modport sink(input valid, out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x,
                out_dst_y, out_dst_w, out_dst_h, h_ratio, v_ratio, status, output ready);
endinterface

// ===== sv/plane_clip_and_scale_check_core.sv =====
// Throughput: one request per cycle while the response channel is not stalled; an input
// register, then a 29-cell restoring divider chain per axis, one quotient bit per cell,
// followed by a multiply stage and an output register.
// Reset: synchronous, active high; clears all valid flags and restores the
// screen size to 1920 by 1080 with all capability bits clear.
module plane_clip_and_scale_check_core
   import pcsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pcsc_req_if.sink    req_chan,
   pcsc_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   logic [12:0]   scr_w_ff, scr_h_ff;
   logic          cap_scale_ff, cap_double_ff, cap_tile_ff;
   logic          en;
   logic          chain_v [0:NumW];
   pcsc_lane_type chain_h [0:NumW];
   pcsc_lane_type chain_vl [0:NumW];
   pcsc_pay_type  chain_p [0:NumW];
   pcsc_lane_type h_in, v_in;
   pcsc_pay_type  pay_in;
   logic          negx, negy;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= ResetWidth;
         scr_h_ff <= ResetHeight;
         cap_scale_ff <= 1'b0;
         cap_double_ff <= 1'b0;
         cap_tile_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            RegWidth: scr_w_ff <= csr_wdata;
            RegHeight: scr_h_ff <= csr_wdata;
            RegScale: cap_scale_ff <= csr_wdata[0];
            RegDouble: cap_double_ff <= csr_wdata[0];
            RegTile: cap_tile_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign en = ~rsp_chan.valid | rsp_chan.ready;
   assign req_chan.ready = en;

   assign negx = req_chan.dst_x[13];
   assign negy = req_chan.dst_y[13];

   always_comb begin
      h_in.num = {req_chan.src_w_q16[28:16], 16'b0};
      h_in.rem = '0;
      h_in.den = req_chan.dst_w;
      h_in.quo = '0;
      v_in.num = {req_chan.src_h_q16[28:16], 16'b0};
      v_in.rem = '0;
      v_in.den = req_chan.dst_h;
      v_in.quo = '0;
      pay_in.sx = req_chan.src_x_q16[31:16];
      pay_in.sy = req_chan.src_y_q16[31:16];
      pay_in.aw = visible(req_chan.dst_x, req_chan.dst_w, scr_w_ff);
      pay_in.ah = visible(req_chan.dst_y, req_chan.dst_h, scr_h_ff);
      pay_in.dxo = negx ? '0 : req_chan.dst_x[12:0];
      pay_in.dyo = negy ? '0 : req_chan.dst_y[12:0];
      pay_in.ovx = negx ? 14'(-req_chan.dst_x) : '0;
      pay_in.ovy = negy ? 14'(-req_chan.dst_y) : '0;
      pay_in.negx = negx;
      pay_in.negy = negy;
      pay_in.lay_ok = (req_chan.fb_layout == LayLinear) ||
                      (req_chan.fb_layout == LayTiled && cap_tile_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_v[0] <= 1'b0;
      end else if (en) begin
         chain_v[0] <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chain_h[0] <= h_in;
         chain_vl[0] <= v_in;
         chain_p[0] <= pay_in;
      end
   end

   for (genvar i = 0; i < NumW; i++) begin : g_cell
      pcsc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .valid_prev (chain_v[i]),
         .h_prev     (chain_h[i]),
         .v_prev     (chain_vl[i]),
         .pay_prev   (chain_p[i]),
         .valid_ff   (chain_v[i+1]),
         .h_ff       (chain_h[i+1]),
         .v_ff       (chain_vl[i+1]),
         .pay_ff     (chain_p[i+1])
      );
   end

   pcsc_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .valid_prev (chain_v[NumW]),
      .h_prev     (chain_h[NumW]),
      .v_prev     (chain_vl[NumW]),
      .pay_prev   (chain_p[NumW]),
      .cap_scale  (cap_scale_ff),
      .cap_double (cap_double_ff),
      .rsp_chan   (rsp_chan)
   );
endmodule

// ===== sv/pcsc_div_cell.sv =====
module pcsc_div_cell
   import pcsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_prev,
   input  pcsc_lane_type h_prev,
   input  pcsc_lane_type v_prev,
   input  pcsc_pay_type  pay_prev,
   output logic          valid_ff,
   output pcsc_lane_type h_ff,
   output pcsc_lane_type v_ff,
   output pcsc_pay_type  pay_ff
);
   pcsc_lane_type h_in;
   pcsc_lane_type v_in;

   function automatic pcsc_lane_type step(input pcsc_lane_type a);
      pcsc_lane_type r;
      logic [13:0] trial;
      logic [13:0] diff;
      logic ge;
      trial = {a.rem, a.num[NumW-1]};
      diff = trial - {1'b0, a.den};
      ge = trial >= {1'b0, a.den};
      r.num = {a.num[NumW-2:0], 1'b0};
      r.rem = ge ? diff[12:0] : trial[12:0];
      r.den = a.den;
      r.quo = {a.quo[NumW-2:0], ge};
      return r;
   endfunction

   assign h_in = step(h_prev);
   assign v_in = step(v_prev);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff <= h_in;
         v_ff <= v_in;
         pay_ff <= pay_prev;
      end
   end
endmodule

// ===== sv/pcsc_finish.sv =====
`include "plane_clip_and_scale_check_core_assert.svh"
module pcsc_finish
   import pcsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_prev,
   input  pcsc_lane_type h_prev,
   input  pcsc_lane_type v_prev,
   input  pcsc_pay_type  pay_prev,
   input  logic          cap_scale,
   input  logic          cap_double,
   pcsc_rsp_if.source    rsp_chan
);
   logic               v1_ff;
   logic [28:0]        hr_ff, vr_ff;
   logic [ProdW-1:0]   pcw_ff, pch_ff, psx_ff, psy_ff;
   pcsc_pay_type       pay1_ff;
   logic [28:0]        hr_in, vr_in;
   logic               v2_ff;
   logic [25:0]        cw_in, ch_in;
   logic [16:0]        sx_in, sy_in;
   logic [1:0]         st_in;
   logic               wok, hok;

   assign hr_in = (h_prev.den == '0) ? RatioMax : h_prev.quo;
   assign vr_in = (v_prev.den == '0) ? RatioMax : v_prev.quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_prev;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hr_ff <= hr_in;
         vr_ff <= vr_in;
         pcw_ff <= ProdW'(pay_prev.aw) * ProdW'(hr_in);
         pch_ff <= ProdW'(pay_prev.ah) * ProdW'(vr_in);
         psx_ff <= ProdW'(pay_prev.ovx) * ProdW'(hr_in);
         psy_ff <= ProdW'(pay_prev.ovy) * ProdW'(vr_in);
         pay1_ff <= pay_prev;
      end
   end

   assign cw_in = pcw_ff[41:16];
   assign ch_in = pch_ff[41:16];
   assign sx_in = (pay1_ff.negx && pay1_ff.aw != '0) ?
                  17'(pay1_ff.sx) + psx_ff[32:16] : 17'(pay1_ff.sx);
   assign sy_in = (pay1_ff.negy && pay1_ff.ah != '0) ?
                  17'(pay1_ff.sy) + psy_ff[32:16] : 17'(pay1_ff.sy);
   assign wok = (cw_in == 26'(pay1_ff.aw)) || (cap_double && hr_ff == DoubleRatio);
   assign hok = (ch_in == 26'(pay1_ff.ah)) || (cap_double && vr_ff == DoubleRatio);

   always_comb begin
      if (!pay1_ff.lay_ok) begin
         st_in = StatLayout;
      end else if (cap_scale || (wok && hok)) begin
         st_in = StatOk;
      end else begin
         st_in = StatScale;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_chan.out_src_x <= sx_in;
         rsp_chan.out_src_y <= sy_in;
         rsp_chan.out_src_w <= cw_in;
         rsp_chan.out_src_h <= ch_in;
         rsp_chan.out_dst_x <= pay1_ff.dxo;
         rsp_chan.out_dst_y <= pay1_ff.dyo;
         rsp_chan.out_dst_w <= pay1_ff.aw;
         rsp_chan.out_dst_h <= pay1_ff.ah;
         rsp_chan.h_ratio <= hr_ff;
         rsp_chan.v_ratio <= vr_ff;
         rsp_chan.status <= st_in;
      end
   end

   assign rsp_chan.valid = v2_ff;

   `PCSC_ASSERT_IMPL(a_zero_den_ratio, clock, reset, valid_prev && h_prev.den == '0, hr_in == RatioMax)
   `PCSC_ASSERT_NEXT(a_layout_status, clock, reset, en && v1_ff && !pay1_ff.lay_ok, rsp_chan.status == StatLayout)
   `PCSC_ASSERT_IMPL(a_hidden_src_zero, clock, reset, v2_ff && rsp_chan.out_dst_w == '0, rsp_chan.out_src_w == '0)
endmodule
